// ===== rtl/core/voxel_chunk_face_culler_defines.svh =====
// Assertion macros shared by the face culler checker.
`ifndef VOXEL_CHUNK_FACE_CULLER_DEFINES_SVH
`define VOXEL_CHUNK_FACE_CULLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while reset is applied.
`define VCFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while reset is applied.
`define VCFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/vcfc_pkg.sv =====
// Types, codes and direction tables for the voxel chunk face culler.
`default_nettype none

package vcfc_pkg;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] pos_x;
		logic [4:0] pos_y;
		logic [4:0] pos_z;
		logic [3:0] color_index;
	} in_item_t;

	typedef struct packed {
		logic       status;
		logic       face_valid;
		logic [2:0] face_dir;
		logic [4:0] out_x;
		logic [4:0] out_y;
		logic [4:0] out_z;
		logic [3:0] face_color;
		logic       last;
	} out_item_t;

	// Item kinds; the spare code is answered as ignored.
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;
	localparam logic [1:0] KIND_SPARE  = 2'd3;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_IGNORED = 1'b1;

	// Datapath operations selected by the control word.
	typedef enum logic [3:0] {
		OP_NONE   = 4'd0,
		OP_CLEAR  = 4'd1,
		OP_ACCEPT = 4'd2,
		OP_RDC    = 4'd3,
		OP_LATCH  = 4'd4,
		OP_NBINIT = 4'd5,
		OP_RDNB   = 4'd6,
		OP_EMIT   = 4'd7,
		OP_ADD    = 4'd8,
		OP_REM    = 4'd9,
		OP_FAIL   = 4'd10
	} op_t;

	// Jump conditions tested by the sequencer.
	typedef enum logic [3:0] {
		C_NEVER      = 4'd0,
		C_START      = 4'd1,
		C_KIND_ADD   = 4'd2,
		C_KIND_REM   = 4'd3,
		C_QUERY_BAD  = 4'd4,
		C_NB_MORE    = 4'd5,
		C_MASK_EMPTY = 4'd6,
		C_MASK_MORE  = 4'd7,
		C_CLR_MORE   = 4'd8
	} cond_t;

	typedef struct packed {
		op_t        op;
		cond_t      cond;
		logic [3:0] target;
		logic       ret;
	} ctl_word_t;

	typedef struct packed {
		logic start;
		logic kind_add;
		logic kind_rem;
		logic query_bad;
		logic nb_more;
		logic mask_empty;
		logic mask_more;
		logic clr_more;
	} cond_flags_t;

	localparam logic [2:0] DIR_PY = 3'd0;
	localparam logic [2:0] DIR_NY = 3'd1;
	localparam logic [2:0] DIR_PX = 3'd2;
	localparam logic [2:0] DIR_NX = 3'd3;
	localparam logic [2:0] DIR_PZ = 3'd4;
	localparam logic [2:0] DIR_NZ = 3'd5;

	localparam logic [5:0] STEP_PLUS  = 6'h01;
	localparam logic [5:0] STEP_MINUS = 6'h3F;

	function automatic logic [5:0] step_x(input logic [2:0] dir);
		case (dir)
			DIR_PX:  return STEP_PLUS;
			DIR_NX:  return STEP_MINUS;
			default: return 6'h00;
		endcase
	endfunction

	function automatic logic [5:0] step_y(input logic [2:0] dir);
		case (dir)
			DIR_PY:  return STEP_PLUS;
			DIR_NY:  return STEP_MINUS;
			default: return 6'h00;
		endcase
	endfunction

	function automatic logic [5:0] step_z(input logic [2:0] dir);
		case (dir)
			DIR_PZ:  return STEP_PLUS;
			DIR_NZ:  return STEP_MINUS;
			default: return 6'h00;
		endcase
	endfunction

	// Lowest set bit of the open-face mask, in face order.
	function automatic logic [2:0] lowest_dir(input logic [5:0] m);
		logic [2:0] r;
		r = DIR_PY;
		for (int i = 5; i >= 0; i--) begin
			if (m[i]) r = 3'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/voxel_chunk_face_culler.sv =====
// Add, remove and face query each run as a sequence of microcode steps; a new item
// is accepted only while busy is low. A query gives one record per open face, and
// one ignored result for a fully enclosed block or when it is turned down before
// the neighbor reads. Each step makes at most one store access. The last result of
// an item is on the result port in the cycle busy falls. After reset a clearing pass
// writes every store entry once, with busy high; results need no flow control.
`default_nettype none

module voxel_chunk_face_culler #(
	parameter int CHUNK_SIZE  = 16,
	parameter int EDGE_BLOCKS = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire vcfc_pkg::in_item_t   item,
	output logic                      busy,
	output vcfc_pkg::out_item_t       result,
	output logic                      result_strobe
);
	import vcfc_pkg::*;

	ctl_word_t   ctl;
	cond_flags_t flags;

	vcfc_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.ctl   (ctl),
		.busy  (busy)
	);

	vcfc_dp #(
		.CHUNK_SIZE (CHUNK_SIZE),
		.EDGE_BLOCKS(EDGE_BLOCKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.ctl          (ctl),
		.flags        (flags),
		.result       (result),
		.result_strobe(result_strobe)
	);

endmodule

`default_nettype wire

// ===== rtl/core/vcfc_seq.sv =====
// Microcode sequencer: program ROM, step counter and jump logic.
`default_nettype none

module vcfc_seq (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire vcfc_pkg::cond_flags_t  flags,
	output vcfc_pkg::ctl_word_t         ctl,
	output logic                        busy
);
	import vcfc_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RDC   = 4'd2;
	localparam logic [3:0] S_DISP  = 4'd3;
	localparam logic [3:0] S_KREM  = 4'd4;
	localparam logic [3:0] S_QCHK  = 4'd5;
	localparam logic [3:0] S_NB    = 4'd6;
	localparam logic [3:0] S_DRAIN = 4'd7;
	localparam logic [3:0] S_MCHK  = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;
	localparam logic [3:0] S_ADD   = 4'd10;
	localparam logic [3:0] S_REM   = 4'd11;
	localparam logic [3:0] S_FAIL  = 4'd12;

	// A taken jump goes to target; otherwise ret returns to idle, else the next step.
	function automatic ctl_word_t ucode(input logic [3:0] s);
		ctl_word_t w;
		w = '{op: OP_NONE, cond: C_NEVER, target: S_IDLE, ret: 1'b1};
		case (s)
			S_CLR:   w = '{op: OP_CLEAR,  cond: C_CLR_MORE,   target: S_CLR,  ret: 1'b1};
			S_IDLE:  w = '{op: OP_ACCEPT, cond: C_START,      target: S_RDC,  ret: 1'b1};
			S_RDC:   w = '{op: OP_RDC,    cond: C_NEVER,      target: S_IDLE, ret: 1'b0};
			S_DISP:  w = '{op: OP_LATCH,  cond: C_KIND_ADD,   target: S_ADD,  ret: 1'b0};
			S_KREM:  w = '{op: OP_NONE,   cond: C_KIND_REM,   target: S_REM,  ret: 1'b0};
			S_QCHK:  w = '{op: OP_NBINIT, cond: C_QUERY_BAD,  target: S_FAIL, ret: 1'b0};
			S_NB:    w = '{op: OP_RDNB,   cond: C_NB_MORE,    target: S_NB,   ret: 1'b0};
			S_DRAIN: w = '{op: OP_NONE,   cond: C_NEVER,      target: S_IDLE, ret: 1'b0};
			S_MCHK:  w = '{op: OP_NONE,   cond: C_MASK_EMPTY, target: S_FAIL, ret: 1'b0};
			S_EMIT:  w = '{op: OP_EMIT,   cond: C_MASK_MORE,  target: S_EMIT, ret: 1'b1};
			S_ADD:   w = '{op: OP_ADD,    cond: C_NEVER,      target: S_IDLE, ret: 1'b1};
			S_REM:   w = '{op: OP_REM,    cond: C_NEVER,      target: S_IDLE, ret: 1'b1};
			S_FAIL:  w = '{op: OP_FAIL,   cond: C_NEVER,      target: S_IDLE, ret: 1'b1};
			default: w = '{op: OP_NONE,   cond: C_NEVER,      target: S_IDLE, ret: 1'b1};
		endcase
		return w;
	endfunction

	logic [3:0] pc_q;
	logic       taken;

	assign ctl  = ucode(pc_q);
	assign busy = (pc_q != S_IDLE);

	always_comb begin
		case (ctl.cond)
			C_START:      taken = flags.start;
			C_KIND_ADD:   taken = flags.kind_add;
			C_KIND_REM:   taken = flags.kind_rem;
			C_QUERY_BAD:  taken = flags.query_bad;
			C_NB_MORE:    taken = flags.nb_more;
			C_MASK_EMPTY: taken = flags.mask_empty;
			C_MASK_MORE:  taken = flags.mask_more;
			C_CLR_MORE:   taken = flags.clr_more;
			default:      taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_CLR;
		end else if (taken) begin
			pc_q <= ctl.target;
		end else if (ctl.ret) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vcfc_dp.sv =====
// Datapath: item registers, voxel store, neighbor address generation and result register.
`default_nettype none

module vcfc_dp #(
	parameter int CHUNK_SIZE  = 16,
	parameter int EDGE_BLOCKS = 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire vcfc_pkg::in_item_t    item,
	input  wire vcfc_pkg::ctl_word_t   ctl,
	output vcfc_pkg::cond_flags_t      flags,
	output vcfc_pkg::out_item_t        result,
	output logic                       result_strobe
);
	import vcfc_pkg::*;

	localparam int SIDE  = CHUNK_SIZE + 2 * EDGE_BLOCKS;
	localparam int DEPTH = SIDE * SIDE * SIDE;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [5:0]    SIDE_C   = 6'(SIDE);
	localparam logic [5:0]    LO_C     = 6'(EDGE_BLOCKS);
	localparam logic [5:0]    HI_C     = 6'(EDGE_BLOCKS + CHUNK_SIZE - 1);
	localparam logic [AW-1:0] ROW_C    = AW'(SIDE);
	localparam logic [AW-1:0] PLANE_C  = AW'(SIDE * SIDE);
	localparam logic [AW-1:0] LAST_A_C = AW'(DEPTH - 1);

	// Bit 4 marks an occupied cell, bits 3..0 hold its color.
	logic [4:0] mem [DEPTH];

	logic [1:0]    kind_q;
	logic [4:0]    x_q, y_q, z_q;
	logic [3:0]    col_q;
	logic [3:0]    cell_col_q;
	logic [2:0]    dir_q;
	logic [5:0]    mask_q;
	logic [4:0]    rd_q;
	logic [AW-1:0] clr_q;
	logic          nb_pend_s1;
	logic [2:0]    nb_dir_s1;
	logic          nb_in_s1;
	out_item_t     res_q;
	out_item_t     res_d;
	logic          strobe_q;

	logic [5:0]    cx, cy, cz;
	logic [5:0]    nx, ny, nz;
	logic          n_in, cen_in, cen_proper, cen_occ, add_ok;
	logic [AW-1:0] lin_addr, mem_addr;
	logic          mem_we, mem_re;
	logic [4:0]    mem_wdata;
	logic [5:0]    mask_rest;
	logic          is_nb;

	assign cx = {1'b0, x_q};
	assign cy = {1'b0, y_q};
	assign cz = {1'b0, z_q};

	// Stepping below zero wraps to a large code, so one compare covers both borders.
	assign is_nb = (ctl.op == OP_RDNB);
	assign nx    = cx + (is_nb ? step_x(dir_q) : 6'h00);
	assign ny    = cy + (is_nb ? step_y(dir_q) : 6'h00);
	assign nz    = cz + (is_nb ? step_z(dir_q) : 6'h00);
	assign n_in  = (nx < SIDE_C) && (ny < SIDE_C) && (nz < SIDE_C);

	assign cen_in     = (cx < SIDE_C) && (cy < SIDE_C) && (cz < SIDE_C);
	assign cen_proper = (cx >= LO_C) && (cx <= HI_C) && (cy >= LO_C) && (cy <= HI_C)
		&& (cz >= LO_C) && (cz <= HI_C);
	assign cen_occ    = cen_in && rd_q[4];
	assign add_ok     = cen_in && !rd_q[4];

	assign lin_addr  = AW'(nx) + ROW_C * AW'(ny) + PLANE_C * AW'(nz);
	assign mem_addr  = (ctl.op == OP_CLEAR) ? clr_q : lin_addr;
	assign mem_re    = (ctl.op == OP_RDC) || is_nb;
	assign mem_we    = (ctl.op == OP_CLEAR) || ((ctl.op == OP_ADD) && add_ok)
		|| ((ctl.op == OP_REM) && cen_occ);
	assign mem_wdata = (ctl.op == OP_ADD) ? {1'b1, col_q} : 5'd0;

	assign mask_rest = mask_q & (mask_q - 6'd1);

	always_comb begin
		flags.start      = start;
		flags.kind_add   = (kind_q == KIND_ADD);
		flags.kind_rem   = (kind_q == KIND_REMOVE);
		flags.query_bad  = (kind_q != KIND_QUERY) || !cen_occ || !cen_proper;
		flags.nb_more    = (dir_q != DIR_NZ);
		flags.mask_empty = (mask_q == 6'd0);
		flags.mask_more  = (mask_rest != 6'd0);
		flags.clr_more   = (clr_q != LAST_A_C);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if ((ctl.op == OP_ACCEPT) && start) begin
			kind_q <= item.kind;
			x_q    <= item.pos_x;
			y_q    <= item.pos_y;
			z_q    <= item.pos_z;
			col_q  <= item.color_index;
		end
		if (ctl.op == OP_LATCH) cell_col_q <= rd_q[3:0];
		nb_dir_s1 <= dir_q;
		nb_in_s1  <= n_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			dir_q      <= DIR_PY;
			mask_q     <= 6'd0;
			nb_pend_s1 <= 1'b0;
		end else begin
			nb_pend_s1 <= is_nb;
			if (ctl.op == OP_CLEAR) clr_q <= clr_q + AW'(1);
			if (ctl.op == OP_NBINIT) begin
				dir_q  <= DIR_PY;
				mask_q <= 6'd0;
			end else if (is_nb) begin
				dir_q <= dir_q + 3'd1;
			end
			// Neighbor data lands in the cycle after its read; an empty or outside cell opens a face.
			if (nb_pend_s1) mask_q[nb_dir_s1] <= !(nb_in_s1 && rd_q[4]);
			if (ctl.op == OP_EMIT) mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (ctl.op == OP_EMIT) || (ctl.op == OP_ADD) || (ctl.op == OP_REM)
				|| (ctl.op == OP_FAIL);
		end
	end

	always_comb begin
		res_d      = '0;
		res_d.last = 1'b1;
		case (ctl.op)
			OP_ADD:  res_d.status = add_ok ? ST_DONE : ST_IGNORED;
			OP_REM:  res_d.status = cen_occ ? ST_DONE : ST_IGNORED;
			OP_EMIT: begin
				res_d.status     = ST_DONE;
				res_d.face_valid = 1'b1;
				res_d.face_dir   = lowest_dir(mask_q);
				res_d.out_x      = x_q;
				res_d.out_y      = y_q;
				res_d.out_z      = z_q;
				res_d.face_color = cell_col_q;
				res_d.last       = (mask_rest == 6'd0);
			end
			default: res_d.status = ST_IGNORED;
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire

// ===== rtl/core/vcfc_checker.sv =====
// Port-level checker for the face culler and its bind to the top level.
`default_nettype none
`include "voxel_chunk_face_culler_defines.svh"

module vcfc_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire vcfc_pkg::out_item_t  result,
	input wire logic                 result_strobe
);
	import vcfc_pkg::*;

	`VCFC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "block not busy after an accepted item")
	`VCFC_ASSERT_NEXT(a_face_run, result_strobe && !result.last, result_strobe, "face records of an item are not back to back")
	`VCFC_ASSERT_NOW(a_plain_last, result_strobe && !result.face_valid, result.last, "a plain record is not the last of its item")
	`VCFC_ASSERT_NOW(a_face_ok, result_strobe && result.face_valid, (result.status == ST_DONE) && (result.face_dir <= DIR_NZ), "face record with bad status or direction")
	`VCFC_ASSERT_NOW(a_result_owned, result_strobe, $past(busy), "result without an item in progress")

endmodule

bind voxel_chunk_face_culler vcfc_checker u_vcfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result       (result),
	.result_strobe(result_strobe)
);

`default_nettype wire
